// File: hdl/wsm_pkg.sv
// Shared types and constants for the wildcard string matcher.
package wsm_pkg;

   localparam int CHAR_W = 8;
   localparam int CMD_W  = 2;

   // Command codes carried on req_tuser.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FINISH = 2'd3;

   // Pattern wildcards.
   localparam logic [CHAR_W-1:0] WILD_ONE = 8'h3F;
   localparam logic [CHAR_W-1:0] WILD_RUN = 8'h2A;

   // Wavefront handed from one cell to the next.
   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] text;
      logic              left_new;
      logic              left_old;
   } wave_type;

endpackage

// File: hdl/wsm_cell.sv
// One pattern cell: a pattern byte, its prefix match bit and a wave stage.
module wsm_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       kill,
   input  logic                       wr_en,
   input  logic [wsm_pkg::CHAR_W-1:0] wr_char,
   input  logic                       wr_bit,
   input  wsm_pkg::wave_type          wave_in,
   output wsm_pkg::wave_type          wave_out,
   output logic                       match_bit
);

   logic [wsm_pkg::CHAR_W-1:0] pat_ff;
   logic                       bit_ff;
   logic                       bit_in;
   wsm_pkg::wave_type          wave_ff;
   wsm_pkg::wave_type          wave_in_next;
   logic                       new_bit;

   // A matching literal or ? takes the diagonal; a run wildcard takes left or up.
   always_comb begin
      if (pat_ff == wsm_pkg::WILD_ONE || pat_ff == wave_in.text) begin
         new_bit = wave_in.left_old;
      end else if (pat_ff == wsm_pkg::WILD_RUN) begin
         new_bit = wave_in.left_new | bit_ff;
      end else begin
         new_bit = 1'b0;
      end
   end

   always_comb begin
      bit_in                = bit_ff;
      wave_in_next.valid    = wave_in.valid;
      wave_in_next.text     = wave_in.text;
      wave_in_next.left_new = new_bit;
      wave_in_next.left_old = bit_ff;
      if (wr_en) begin
         bit_in = wr_bit;
      end else if (wave_in.valid) begin
         bit_in = new_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_ff <= wr_char;
      end
      bit_ff <= bit_in;
      if (reset || kill) begin
         wave_ff.valid <= 1'b0;
      end else begin
         wave_ff <= wave_in_next;
      end
   end

   assign wave_out  = wave_ff;
   assign match_bit = bit_ff;

endmodule

// File: hdl/wildcard_string_matcher_core.sv
// Top level of the wildcard string matcher: control, prefix zero and the row of cells.
//
//   Channel | Direction | Content
//   req_    | in        | tuser[1:0] cmd, tdata[7:0] ch
//   rsp_    | out       | tdata[0] matched, tdata[1] overflow
//
// Clear, append and finish are handled without leaving the idle state, and so is a
// text byte with an empty pattern. Any other text byte holds off the input while its
// update wave walks down the row of cells one cell per cycle, and until the result
// is loaded after the wave has passed the last stored cell.
// Reset is synchronous and active high; it empties the pattern and kills any
// wave in flight. A result waits in the output register while rsp_tready is
// low, and a new transaction is taken only once that register can be freed.
module wildcard_string_matcher_core #(
   parameter int MAX_PATTERN = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] matched, [1] overflow, [7:2] zero
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   // Controller states.
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WAVE = 1'b1;

   logic                 state_ff, state_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic                 seen_ff, seen_in;
   logic                 bit0_ff, bit0_in;
   wsm_pkg::wave_type    launch_ff, launch_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_match_ff, rsp_match_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic                 slot_free;
   logic                 accept;
   logic                 kill;
   logic                 wr_go;
   logic                 wr_bit;
   logic                 full;
   logic [MAX_PATTERN:0] row;

   // Wave registers: entry zero is the launch stage, entry j leaves cell j.
   wsm_pkg::wave_type    wave_chain [0:MAX_PATTERN];

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign full       = (len_ff == LEN_W'(MAX_PATTERN));

   // Appends are ignored once text has arrived, and dropped when the store is full.
   assign wr_go  = accept && (req_tuser == wsm_pkg::CMD_APPEND) && !seen_ff && !full;
   assign wr_bit = (req_tdata == wsm_pkg::WILD_RUN) && row[len_ff];

   assign row[0]        = bit0_ff;
   assign wave_chain[0] = launch_ff;

   genvar j;
   generate
      for (j = 1; j <= MAX_PATTERN; j++) begin : g_cell
         wsm_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .kill      (kill),
            .wr_en     (wr_go && (len_ff == LEN_W'(j - 1))),
            .wr_char   (req_tdata),
            .wr_bit    (wr_bit),
            .wave_in   (wave_chain[j-1]),
            .wave_out  (wave_chain[j]),
            .match_bit (row[j])
         );
      end
   endgenerate

   always_comb begin
      state_in          = state_ff;
      len_in            = len_ff;
      cnt_in            = cnt_ff;
      ovf_in            = ovf_ff;
      seen_in           = seen_ff;
      bit0_in           = bit0_ff;
      kill              = 1'b0;
      launch_in.valid    = 1'b0;
      launch_in.text     = req_tdata;
      launch_in.left_new = 1'b0;
      launch_in.left_old = bit0_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_match_in      = rsp_match_ff;
      rsp_ovf_in        = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  wsm_pkg::CMD_CLEAR: begin
                     len_in  = '0;
                     ovf_in  = 1'b0;
                     seen_in = 1'b0;
                     bit0_in = 1'b1;
                     kill    = 1'b1;
                  end
                  wsm_pkg::CMD_APPEND: begin
                     if (!seen_ff) begin
                        if (full) begin
                           ovf_in = 1'b1;
                        end else begin
                           len_in = len_ff + LEN_W'(1);
                        end
                     end
                  end
                  wsm_pkg::CMD_TEXT: begin
                     seen_in = 1'b1;
                     bit0_in = 1'b0;
                     if (len_ff == '0) begin
                        // An empty pattern never matches non-empty text.
                        rsp_valid_in = 1'b1;
                        rsp_match_in = 1'b0;
                        rsp_ovf_in   = ovf_ff;
                     end else begin
                        launch_in.valid = 1'b1;
                        cnt_in          = len_ff;
                        state_in        = ST_WAVE;
                     end
                  end
                  wsm_pkg::CMD_FINISH: begin
                     rsp_valid_in = 1'b1;
                     rsp_match_in = row[len_ff];
                     rsp_ovf_in   = ovf_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WAVE: begin
            // The count reaches zero once the wave has updated the last stored cell.
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - LEN_W'(1);
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_match_in = row[len_ff];
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         len_ff          <= '0;
         cnt_ff          <= '0;
         ovf_ff          <= 1'b0;
         seen_ff         <= 1'b0;
         bit0_ff         <= 1'b1;
         launch_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         seen_ff      <= seen_in;
         bit0_ff      <= bit0_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_match_ff <= rsp_match_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ovf_ff, rsp_match_ff};

   // A launched wave always belongs to a text byte that is still being worked on.
   a_launch_in_wave: assert property (@(posedge clock) disable iff (reset)
      launch_ff.valid |-> (state_ff == ST_WAVE))
      else $error("wave launched outside the wave state");

   // The overflow flag is only ever set with a full store.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> full)
      else $error("overflow flagged with room left in the store");

   // No wave reaches the end of the row before text has arrived since the last clear.
   a_no_wave_before_text: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> !wave_chain[MAX_PATTERN].valid)
      else $error("wave in the row without text");

   // When the wave has passed the last stored cell and the output is free, a result follows.
   a_wave_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAVE && cnt_ff == '0 && slot_free) |=> rsp_tvalid)
      else $error("text result lost");

endmodule

// File: test/wildcard_string_matcher_core_checker.sv
`timescale 1ns / 1ps
// Checker for the wildcard string matcher: it predicts every response and compares it.
module wildcard_string_matcher_core_checker #(
   parameter int MAX_PATTERN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] ch
   input  logic [1:0]        req_tuser,   // [1:0] cmd
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [7:0]        rsp_tdata,   // [0] matched, [1] overflow, [7:2] zero
   output int unsigned       fail_count,
   output int unsigned       pending,
   output int unsigned       results_seen,
   output int unsigned       matches_seen,
   output int unsigned       overflows_seen
);

   typedef struct {
      logic matched;
      logic overflow;
   } verdict_type;

   logic [wsm_pkg::CHAR_W-1:0] pattern_bytes [MAX_PATTERN];
   int unsigned          pattern_len;
   logic [MAX_PATTERN:0] prefix_hits;   // Bit j: the first j pattern bytes match the text.
   logic                 truncated;
   logic                 text_started;
   verdict_type          expected_verdicts [$];

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic clear_matcher();
      pattern_len  = 0;
      prefix_hits  = '0;
      prefix_hits[0] = 1'b1;
      truncated    = 1'b0;
      text_started = 1'b0;
   endtask

   // One text byte moves the whole row of prefix bits forward.
   task automatic step_text(input logic [wsm_pkg::CHAR_W-1:0] t);
      logic diag;
      logic up;
      logic [wsm_pkg::CHAR_W-1:0] c;
      diag = prefix_hits[0];
      prefix_hits[0] = 1'b0;
      for (int unsigned j = 1; j <= pattern_len; j++) begin
         up = prefix_hits[j];
         c  = pattern_bytes[j-1];
         if (c == wsm_pkg::WILD_ONE || c == t) begin
            prefix_hits[j] = diag;
         end else if (c == wsm_pkg::WILD_RUN) begin
            prefix_hits[j] = prefix_hits[j-1] | up;
         end else begin
            prefix_hits[j] = 1'b0;
         end
         diag = up;
      end
      text_started = 1'b1;
   endtask

   task automatic apply_request(input logic [wsm_pkg::CMD_W-1:0] cmd,
                                input logic [wsm_pkg::CHAR_W-1:0] ch);
      case (cmd)
         wsm_pkg::CMD_CLEAR: begin
            clear_matcher();
         end
         wsm_pkg::CMD_APPEND: begin
            // Pattern bytes that come after text are ignored altogether.
            if (!text_started) begin
               if (pattern_len >= MAX_PATTERN) begin
                  truncated = 1'b1;
               end else begin
                  pattern_bytes[pattern_len] = ch;
                  prefix_hits[pattern_len+1] =
                     (ch == wsm_pkg::WILD_RUN) && prefix_hits[pattern_len];
                  pattern_len++;
               end
            end
         end
         wsm_pkg::CMD_TEXT: begin
            step_text(ch);
            expected_verdicts.push_back('{prefix_hits[pattern_len], truncated});
         end
         default: begin
            expected_verdicts.push_back('{prefix_hits[pattern_len], truncated});
         end
      endcase
   endtask

   task automatic check_response(input logic [7:0] data);
      verdict_type want;
      if (expected_verdicts.size() == 0) begin
         report_mismatch($sformatf("response 0x%02h with no request outstanding", data));
      end else begin
         want = expected_verdicts.pop_front();
         if (data[0] !== want.matched) begin
            report_mismatch($sformatf("matched is %b, predicted %b", data[0], want.matched));
         end
         if (data[1] !== want.overflow) begin
            report_mismatch($sformatf("overflow is %b, predicted %b", data[1], want.overflow));
         end
         if (data[7:2] !== '0) begin
            report_mismatch($sformatf("padding bits are %b, not zero", data[7:2]));
         end
      end
      results_seen++;
      if (data[0] === 1'b1) begin
         matches_seen++;
      end
      if (data[1] === 1'b1) begin
         overflows_seen++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_matcher();
         expected_verdicts.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_response(rsp_tdata);
         end
      end
      pending = expected_verdicts.size();
   end

endmodule

// File: test/wildcard_string_matcher_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the wildcard string matcher: clock, reset, stimulus and verdict.
module wildcard_string_matcher_core_test;

   localparam int unsigned MAX_PATTERN  = 64;
   localparam int unsigned ITEM_TARGET  = 1050;
   // The slowest transaction is a text byte against a full store with gaps drawn
   // on both sides; this limit leaves ample margin over it in a correct run.
   localparam int unsigned IDLE_LIMIT   = 1000;
   // A text byte keeps the matcher busy while its wave passes the stored pattern bytes.
   localparam int unsigned DRAIN_CYCLES = 100;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;                  // [7:0] ch
   logic [1:0] req_tuser  = wsm_pkg::CMD_CLEAR;  // [1:0] cmd
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;                        // [0] matched, [1] overflow, [7:2] zero

   int unsigned fail_count;
   int unsigned pending;
   int unsigned results_seen;
   int unsigned matches_seen;
   int unsigned overflows_seen;

   int unsigned requests_sent = 0;
   int unsigned texts_sent    = 0;
   int unsigned clears_sent   = 0;
   int unsigned idle_cycles   = 0;

   // When a side is calm it never idles, which gives back-to-back stretches.
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   wildcard_string_matcher_core #(
      .MAX_PATTERN(MAX_PATTERN)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   wildcard_string_matcher_core_checker #(
      .MAX_PATTERN(MAX_PATTERN)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .results_seen  (results_seen),
      .matches_seen  (matches_seen),
      .overflows_seen(overflows_seen)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The run is ended if neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles.", IDLE_LIMIT);
         $display("wildcard_string_matcher_core_test NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int unsigned draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 13);
   endfunction

   // Pattern bytes come mostly from a small alphabet, so that text can hit them,
   // with wildcards and the occasional arbitrary byte mixed in.
   function automatic logic [7:0] pattern_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return "a";
         4, 5:       return "b";
         6:          return wsm_pkg::WILD_ONE;
         7:          return wsm_pkg::WILD_RUN;
         8:          return "c";
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Text may also carry the wildcard characters, which are literal there.
   function automatic logic [7:0] text_char();
      case ($urandom_range(0, 7))
         0, 1, 2: return "a";
         3, 4:    return "b";
         5:       return "c";
         6:       return $urandom_range(0, 1) ? wsm_pkg::WILD_RUN : wsm_pkg::WILD_ONE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Presents one request transaction and returns at the edge that takes it.
   // The valid stays high afterwards unless the next call draws a gap, so it
   // is never lowered and raised again in the same time step.
   task automatic send_request(input logic [wsm_pkg::CMD_W-1:0] cmd,
                               input logic [wsm_pkg::CHAR_W-1:0] ch);
      int unsigned gap;
      gap = draw_gap(req_calm);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (cmd == wsm_pkg::CMD_TEXT) begin
         texts_sent++;
      end
      if (cmd == wsm_pkg::CMD_CLEAR) begin
         clears_sent++;
      end
   endtask

   // One random session: a clear, a pattern, and then text that is built from
   // the pattern so that a good share of sessions match. Stray finishes and
   // appends after text are sprinkled in; a few sessions skip the clear and
   // carry on from the previous state.
   task automatic run_random_sequence(input bit long_pattern);
      logic [7:0]  pattern [$];
      logic [7:0]  text [$];
      int unsigned plen;
      int unsigned used;
      int unsigned runs;
      if ($urandom_range(0, 4) == 0) begin
         req_calm = ~req_calm;
      end
      if (long_pattern || $urandom_range(0, 9) != 0) begin
         send_request(wsm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
      end
      if (long_pattern || $urandom_range(0, 15) == 0) begin
         plen = $urandom_range(MAX_PATTERN, MAX_PATTERN + 6);
      end else if ($urandom_range(0, 7) == 0) begin
         plen = $urandom_range(9, MAX_PATTERN - 1);
      end else begin
         plen = $urandom_range(0, 8);
      end
      for (int unsigned k = 0; k < plen; k++) begin
         pattern.push_back(pattern_char());
         send_request(wsm_pkg::CMD_APPEND, pattern[k]);
         if ($urandom_range(0, 15) == 0) begin
            send_request(wsm_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
         end
      end

      // Only the bytes that fit in the store shape the text.
      used = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
      for (int unsigned k = 0; k < used; k++) begin
         if (pattern[k] == wsm_pkg::WILD_ONE) begin
            text.push_back(text_char());
         end else if (pattern[k] == wsm_pkg::WILD_RUN) begin
            runs = $urandom_range(0, 3);
            repeat (runs) text.push_back(text_char());
         end else begin
            text.push_back(($urandom_range(0, 7) == 0) ? text_char() : pattern[k]);
         end
      end
      if ($urandom_range(0, 4) == 0) begin
         runs = $urandom_range(1, 3);
         repeat (runs) text.push_back(text_char());
      end

      foreach (text[k]) begin
         send_request(wsm_pkg::CMD_TEXT, text[k]);
         if ($urandom_range(0, 5) == 0) begin
            send_request(wsm_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 29) == 0) begin
            send_request(wsm_pkg::CMD_APPEND, pattern_char());
         end
      end
      send_request(wsm_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
   endtask

   // The receiving side waits a drawn number of cycles before each response
   // transaction and switches now and then into a mode with no stalls.
   initial begin
      int unsigned gap;
      forever begin
         if ($urandom_range(0, 39) == 0) begin
            rsp_calm = ~rsp_calm;
         end
         gap = draw_gap(rsp_calm);
         if (gap != 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // An empty pattern matches until the first text byte arrives.
      send_request(wsm_pkg::CMD_FINISH, 8'h00);
      send_request(wsm_pkg::CMD_TEXT,   8'hFF);
      send_request(wsm_pkg::CMD_FINISH, 8'hFF);

      // A lone star matches anything; a text star meets the pattern star as a literal.
      send_request(wsm_pkg::CMD_CLEAR,  8'hFF);
      send_request(wsm_pkg::CMD_APPEND, wsm_pkg::WILD_RUN);
      send_request(wsm_pkg::CMD_FINISH, 8'h00);
      send_request(wsm_pkg::CMD_TEXT,   wsm_pkg::WILD_RUN);
      send_request(wsm_pkg::CMD_TEXT,   8'h00);

      // Extreme byte values as literals, a question mark in both pattern and
      // text, a repeated finish, and a pattern byte that arrives after text.
      send_request(wsm_pkg::CMD_CLEAR,  8'h00);
      send_request(wsm_pkg::CMD_APPEND, 8'hFF);
      send_request(wsm_pkg::CMD_APPEND, wsm_pkg::WILD_ONE);
      send_request(wsm_pkg::CMD_APPEND, 8'h00);
      send_request(wsm_pkg::CMD_TEXT,   8'hFF);
      send_request(wsm_pkg::CMD_TEXT,   wsm_pkg::WILD_ONE);
      send_request(wsm_pkg::CMD_FINISH, 8'h00);
      send_request(wsm_pkg::CMD_TEXT,   8'h00);
      send_request(wsm_pkg::CMD_APPEND, "a");
      send_request(wsm_pkg::CMD_FINISH, 8'hFF);
      send_request(wsm_pkg::CMD_TEXT,   "a");

      // Stars on both sides of a literal, with a finish after the text.
      send_request(wsm_pkg::CMD_CLEAR,  8'h00);
      send_request(wsm_pkg::CMD_APPEND, wsm_pkg::WILD_RUN);
      send_request(wsm_pkg::CMD_APPEND, "a");
      send_request(wsm_pkg::CMD_APPEND, wsm_pkg::WILD_RUN);
      send_request(wsm_pkg::CMD_TEXT,   "b");
      send_request(wsm_pkg::CMD_TEXT,   "a");
      send_request(wsm_pkg::CMD_FINISH, 8'h00);

      // The first random session fills the store, and may run past its end.
      run_random_sequence(1'b1);
      while (requests_sent < ITEM_TARGET) begin
         run_random_sequence(1'b0);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request transactions (%0d text bytes, %0d clears).",
               requests_sent, texts_sent, clears_sent);
      $display("Checked %0d responses: %0d matched, %0d flagged overflow, %0d mismatches.",
               results_seen, matches_seen, overflows_seen, fail_count);
      if (fail_count == 0) begin
         $display("wildcard_string_matcher_core_test OK");
      end else begin
         $display("wildcard_string_matcher_core_test NOT OK");
      end
      $finish;
   end

endmodule
